>>> hdl/tspc_pkg.sv
// Shared constants, types and the quarter-wave sine table for the three-phase PWM compare block.
package tspc_pkg;

	// table and period sizing
	localparam int SINE_TABLE_BITS = 10;
	localparam int PERIOD_BITS     = 16;
	localparam int QTR_BITS        = SINE_TABLE_BITS - 2;
	localparam int QTR             = 1 << QTR_BITS;

	// phase offsets, fractions of one cycle in 0.32
	localparam logic [31:0] THIRD_CYCLE     = 32'h5555_5555;
	localparam logic [31:0] TWO_THIRD_CYCLE = 32'hAAAA_AAAB;

	// duty midpoint in 0.16
	localparam logic [15:0] DUTY_MID = 16'h8000;

	// only the low PERIOD_BITS bits of period_top take part
	localparam logic [15:0] PERIOD_MASK = (PERIOD_BITS >= 16) ? 16'hFFFF :
		16'((32'd1 << PERIOD_BITS) - 32'd1);

	// Q2.30 constants for the table build
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1073741824;

	// first-quadrant table, entries 0..QTR inclusive, magnitude in Q0.15
	typedef logic [QTR:0][14:0] qsine_tab_t;

	// stage advance enables shared by the lanes
	typedef struct packed {
		logic en_s2;
		logic en_s3;
	} stall_ctl_t;

	// Taylor series to x^13 in Horner form, floor at every step
	function automatic qsine_tab_t qsine_build();
		qsine_tab_t  tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] d;
		logic [63:0] s;
		for (int j = 0; j <= QTR; j++) begin
			x  = (HALF_PI_Q30 * 64'(j)) >> QTR_BITS;
			x2 = (x * x) >> 30;
			t  = ONE_Q30;
			d  = ((x2 * t) >> 30) / 64'd156;
			t  = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
			d  = ((x2 * t) >> 30) / 64'd110;
			t  = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
			d  = ((x2 * t) >> 30) / 64'd72;
			t  = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
			d  = ((x2 * t) >> 30) / 64'd42;
			t  = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
			d  = ((x2 * t) >> 30) / 64'd20;
			t  = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
			d  = ((x2 * t) >> 30) / 64'd6;
			t  = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
			s  = (x * t) >> 30;
			s  = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
			if (s > 64'd32767) begin
				s = 64'd32767;
			end
			tab[j] = s[14:0];
		end
		return tab;
	endfunction

	localparam qsine_tab_t QSINE_TAB = qsine_build();

endpackage

>>> hdl/tspc_phase_lane.sv
// One phase lane: sine lookup with quadrant folding, then duty scaled to a compare value.
module tspc_phase_lane (
	input  logic                    clk,
	input  tspc_pkg::stall_ctl_t    ctl,
	input  logic [31:0]             phase,
	input  logic [15:0]             period_top,
	output logic [15:0]             compare
);

	localparam int QB = tspc_pkg::QTR_BITS;
	localparam int TB = tspc_pkg::SINE_TABLE_BITS;

	logic [TB-1:0] idx;
	logic [1:0]    quad;
	logic [QB-1:0] j;
	logic [QB:0]   jm;
	logic [14:0]   mag_s2;
	logic          neg_s2;
	logic [15:0]   duty;
	logic [31:0]   prod;
	logic [15:0]   compare_s3;

	// table index from the top phase bits, mirrored in odd quadrants
	always_comb begin
		idx  = phase[31 -: TB];
		quad = idx[TB-1 -: 2];
		j    = idx[QB-1:0];
		jm   = quad[0] ? ((QB + 1)'(tspc_pkg::QTR) - {1'b0, j}) : {1'b0, j};
	end

	// stage 2: sine magnitude and sign
	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			mag_s2 <= tspc_pkg::QSINE_TAB[jm];
			neg_s2 <= quad[1];
		end
	end

	// duty = (1 + sin) / 2; magnitude stays below the midpoint so no overflow
	always_comb begin
		duty = neg_s2 ? (tspc_pkg::DUTY_MID - {1'b0, mag_s2})
		              : (tspc_pkg::DUTY_MID + {1'b0, mag_s2});
		prod = period_top * duty;
	end

	// stage 3: compare = (top * duty) >> 16
	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			compare_s3 <= prod[31:16];
		end
	end

	assign compare = compare_s3;

endmodule

>>> hdl/three_phase_sine_pwm_compare_top.sv
// Three-phase sinusoidal PWM compare generator, top level.
// Pipeline: 3 stages; a word passes the phase_s1, stage 2 and stage 3 registers in turn.
// Throughput: one word per cycle while m_tready is high; phase multiply, table lookup
// and compare multiply each take one stage; a stall holds only the stages that cannot move on.
// Reset: arst_n clears valid bits and period_top (to 0) asynchronously; data registers
// are not reset.
module three_phase_sine_pwm_compare_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] time_sec, [63:32] freq_hz
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [15:0] compare_a, [31:16] compare_b, [47:32] compare_c
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata  // period_top
);

	logic [15:0]          period_top_q;
	logic                 valid_s1;
	logic                 valid_s2;
	logic                 valid_s3;
	logic                 en_s1;
	tspc_pkg::stall_ctl_t ctl;
	logic [31:0]          prod;
	logic [31:0]          phase_s1;
	logic [31:0]          phase_b;
	logic [31:0]          phase_c;
	logic [15:0]          compare_a;
	logic [15:0]          compare_b;
	logic [15:0]          compare_c;

	// period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_top_q <= '0;
		end else if (cfg_we) begin
			period_top_q <= cfg_wdata & tspc_pkg::PERIOD_MASK;
		end
	end

	// a stage advances when it is empty or the next one advances
	always_comb begin
		ctl.en_s3 = !valid_s3 || m_tready;
		ctl.en_s2 = !valid_s2 || ctl.en_s3;
		en_s1     = !valid_s1 || ctl.en_s2;
	end

	assign s_tready = en_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= s_tvalid;
			end
			if (ctl.en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ctl.en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// stage 1: phase is the fractional word of time * freq (low 32 bits of the product)
	assign prod = s_tdata[31:0] * s_tdata[63:32];

	always_ff @(posedge clk) begin
		if (en_s1) begin
			phase_s1 <= prod;
		end
	end

	// phase B and C offsets, wrap modulo one cycle
	assign phase_b = phase_s1 + tspc_pkg::THIRD_CYCLE;
	assign phase_c = phase_s1 + tspc_pkg::TWO_THIRD_CYCLE;

	tspc_phase_lane u_lane_a (
		.clk        (clk),
		.ctl        (ctl),
		.phase      (phase_s1),
		.period_top (period_top_q),
		.compare    (compare_a)
	);

	tspc_phase_lane u_lane_b (
		.clk        (clk),
		.ctl        (ctl),
		.phase      (phase_b),
		.period_top (period_top_q),
		.compare    (compare_b)
	);

	tspc_phase_lane u_lane_c (
		.clk        (clk),
		.ctl        (ctl),
		.phase      (phase_c),
		.period_top (period_top_q),
		.compare    (compare_c)
	);

	// output word
	assign m_tvalid = valid_s3;
	assign m_tdata  = {compare_c, compare_b, compare_a};

endmodule

>>> tb/sv/three_phase_sine_pwm_compare_chk.sv
// Scoreboard for the three-phase PWM compare block: predicts every output word and checks it.
module three_phase_sine_pwm_compare_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,    // [31:0] time_sec, [63:32] freq_hz
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,    // [15:0] compare_a, [31:16] compare_b, [47:32] compare_c
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,  // period_top
	output int          fail_count,
	output int          pending
);

	// sine lookup sizing and fixed-point constants
	localparam int          ROM_BITS    = 10;
	localparam int          QUAD_BITS   = ROM_BITS - 2;
	localparam int          QUAD_PTS    = 1 << QUAD_BITS;
	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
	localparam logic [63:0] UNIT_Q30    = 64'd1 << 30;
	localparam logic [31:0] PHASE_B_OFS = 32'h5555_5555;
	localparam logic [31:0] PHASE_C_OFS = 32'hAAAA_AAAB;
	// keep the log short when the block is badly broken
	localparam int          MAX_REPORTS = 60;

	// one output word, compare_a in the low bits
	typedef struct packed {
		logic [15:0] c;
		logic [15:0] b;
		logic [15:0] a;
	} compare_set_t;

	logic [14:0]  sine_mag [0:QUAD_PTS];
	logic [15:0]  period_shadow = 16'd0;
	compare_set_t compare_q [$];
	compare_set_t want_set;
	compare_set_t got_set;
	int           errs = 0;

	// first-quadrant magnitude, Taylor series to x^13 in Horner form, floor on each step
	function automatic logic [14:0] taylor_sine(int j);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] d;
		logic [63:0] s;
		x  = (PI_HALF_Q30 * 64'(j)) >> QUAD_BITS;
		x2 = (x * x) >> 30;
		t  = UNIT_Q30;
		// divisors (2n)(2n+1) from n = 6 down to 1
		for (int n = 6; n >= 1; n--) begin
			d = ((x2 * t) >> 30) / 64'((2 * n) * (2 * n + 1));
			t = (d >= UNIT_Q30) ? 64'd0 : UNIT_Q30 - d;
		end
		s = (x * t) >> 30;
		s = (s * 64'd32767 + (UNIT_Q30 >> 1)) >> 30;
		return (s > 64'd32767) ? 15'h7FFF : s[14:0];
	endfunction

	initial begin
		for (int j = 0; j <= QUAD_PTS; j++) begin
			sine_mag[j] = taylor_sine(j);
		end
	end

	// compare value of one phase: quarter-wave lookup, duty in 0.16, scale by period
	function automatic logic [15:0] compare_of_phase(logic [31:0] ph, logic [15:0] top);
		logic [ROM_BITS-1:0] idx;
		logic [1:0]          quad;
		int                  j;
		int                  sine;
		int                  duty;
		logic [31:0]         prod;
		idx  = ph[31 -: ROM_BITS];
		quad = idx[ROM_BITS-1 -: 2];
		j    = int'(idx[QUAD_BITS-1:0]);
		sine = int'(sine_mag[quad[0] ? QUAD_PTS - j : j]);
		if (quad[1]) begin
			sine = -sine;
		end
		duty = 32768 + sine;
		if (duty > 65535) begin
			duty = 65535;
		end
		if (duty < 0) begin
			duty = 0;
		end
		prod = 32'(top) * 32'(duty[15:0]);
		return prod[31:16];
	endfunction

	// fractional part of time * frequency is the phase of A; B and C are offset by thirds
	function automatic compare_set_t predict_compares(logic [63:0] word, logic [15:0] top);
		logic [63:0]  prod;
		logic [31:0]  ph;
		compare_set_t r;
		prod = 64'(word[31:0]) * 64'(word[63:32]);
		ph   = prod[31:0];
		r.a  = compare_of_phase(ph, top);
		r.b  = compare_of_phase(ph + PHASE_B_OFS, top);
		r.c  = compare_of_phase(ph + PHASE_C_OFS, top);
		return r;
	endfunction

	task automatic check_field(string name, logic [15:0] want, logic [15:0] seen);
		if (want !== seen) begin
			errs++;
			if (errs <= MAX_REPORTS) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
			end
		end
	endtask

	// output side first (oldest expectation), then new input words, then register writes
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_set = compare_set_t'(m_tdata);
				if (compare_q.size() == 0) begin
					errs++;
					if (errs <= MAX_REPORTS) begin
						$display("%0t: unexpected word, expected none, got %h", $time, m_tdata);
					end
				end else begin
					want_set = compare_q.pop_front();
					check_field("compare_a", want_set.a, got_set.a);
					check_field("compare_b", want_set.b, got_set.b);
					check_field("compare_c", want_set.c, got_set.c);
				end
			end
			if (s_tvalid && s_tready) begin
				compare_q.push_back(predict_compares(s_tdata, period_shadow));
			end
			if (cfg_we) begin
				period_shadow = cfg_wdata;
			end
		end
		fail_count <= errs;
		pending    <= compare_q.size();
	end

endmodule

>>> tb/sv/three_phase_sine_pwm_compare_top_tb.sv
// Stimulus and verdict for the three-phase PWM compare block, with the scoreboard beside it.
module three_phase_sine_pwm_compare_top_tb;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata   = 64'd0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;
	logic        cfg_we    = 1'b0;
	logic [15:0] cfg_wdata = 16'd0;
	int          fail_count;
	int          pending;

	// idling modes: tx_burst for the stimulus, rx_burst and rx_hold for the receiver
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	bit rx_hold  = 1'b0;

	three_phase_sine_pwm_compare_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	three_phase_sine_pwm_compare_chk chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	initial begin
		#4000000;
		$display("CHECKS FAILED");
		$finish;
	end

	// offer one input word after a random gap; valid stays high when the gap is zero
	task automatic send_word(input logic [31:0] t_in, input logic [31:0] f_in);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {f_in, t_in};
		do @(posedge clk); while (!s_tready);
	endtask

	// stop offering and wait until every expected word is out
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_period(input logic [15:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [31:0] corner_value();
		case ($urandom_range(0, 4))
			0: return 32'h0000_0000;
			1: return 32'h0000_0001;
			2: return 32'hFFFF_FFFF;
			3: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	// random word: full range, direct phase, realistic time/frequency, corner values, or power-of-two frequency
	task automatic send_random();
		logic [31:0] t;
		logic [31:0] f;
		case ($urandom_range(0, 4))
			0: begin
				t = $urandom;
				f = $urandom;
			end
			1: begin
				t = 32'd1;
				f = $urandom;
			end
			2: begin
				t = $urandom_range(0, 32'h00FF_FFFF);
				f = $urandom_range(32'h0000_8000, 32'h00C8_0000);
			end
			3: begin
				t = corner_value();
				f = corner_value();
			end
			default: begin
				t = $urandom;
				f = 32'h0001_0000 << $urandom_range(0, 12);
			end
		endcase
		send_word(t, f);
	endtask

	// receiver: random stalls, zero-stall stretches, and one long hold-off on request
	initial begin
		int stall;
		int words;
		bit held;
		words = 0;
		held  = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold && !held) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				held = 1'b1;
			end
			if (words % 64 == 0) begin
				rx_burst = ($urandom_range(0, 3) == 0);
			end
			stall = rx_burst ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			words++;
		end
	end

	// main stimulus
	initial begin
		logic [15:0] period_plan [0:7];
		period_plan[0] = 16'd1;
		period_plan[1] = 16'h8000;
		period_plan[2] = 16'($urandom_range(2, 65533));
		period_plan[3] = 16'hFFFE;
		period_plan[4] = 16'd0;
		period_plan[5] = 16'($urandom_range(2, 65533));
		period_plan[6] = 16'hFFFF;
		period_plan[7] = 16'd255;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// period_top still at reset: all compares are zero
		send_word(32'd1, 32'h4000_0000);
		send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);

		// directed words at full period
		set_period(16'hFFFF);
		send_word(32'h0000_0000, 32'h0000_0000);   // zero time and frequency
		send_word(32'h0000_0000, 32'hFFFF_FFFF);
		send_word(32'hFFFF_FFFF, 32'h0000_0000);
		send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);   // product wraps to phase one lsb
		send_word(32'h0001_0000, 32'h0001_0000);   // whole cycle, phase zero
		send_word(32'h0000_8000, 32'h0001_0000);   // half cycle
		send_word(32'h0000_0001, 32'h4000_0000);   // quadrant boundaries
		send_word(32'h0000_0001, 32'h8000_0000);
		send_word(32'h0000_0001, 32'hC000_0000);
		send_word(32'h0000_0001, 32'h3FFF_FFFF);
		send_word(32'h0000_0001, 32'h7FFF_FFFF);
		send_word(32'h0000_0001, 32'hFFFF_FFFF);
		send_word(32'h0000_0001, 32'h5555_5555);   // phase A lands on the B and C offsets
		send_word(32'h0000_0001, 32'hAAAA_AAAB);
		send_word(32'h0000_0001, 32'h2AAA_AAAB);
		send_word(32'h0000_0001, 32'h0040_0000);   // first table step
		send_word(32'h0000_0001, 32'h003F_FFFF);
		send_word(32'h1234_5678, 32'h9ABC_DEF0);   // integer cycles dropped
		send_word(32'h8000_0000, 32'h8000_0000);

		// random phases, one period setting each
		for (int k = 0; k < 8; k++) begin
			set_period(period_plan[k]);
			if (k == 2) begin
				rx_hold = 1'b1;
			end
			for (int i = 0; i < 250; i++) begin
				if (k == 2 && i < 150) begin
					tx_burst = 1'b1;
				end else if (i % 40 == 0) begin
					tx_burst = ($urandom_range(0, 3) == 0);
				end
				send_random();
			end
		end

		drain();
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> three_phase_sine_pwm_compare_top.f
hdl/tspc_pkg.sv
hdl/tspc_phase_lane.sv
hdl/three_phase_sine_pwm_compare_top.sv
tb/sv/three_phase_sine_pwm_compare_chk.sv
tb/sv/three_phase_sine_pwm_compare_top_tb.sv
